[hw/rtl/fcd_pkg.sv]
// ----------------------------------------------------------------------------
// fcd_pkg
// Types and constants shared by the framed command deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcd_pkg;

  // Length of a new-timings packet; also the number of bytes the classifier sees
  localparam int unsigned TIMING_LEN = 9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] BORDER_RESET = 8'd126;
  localparam logic [7:0] START_RESET  = 8'd85;

  // Signatures in the two low bits of the first payload byte
  localparam logic [1:0] LOW2_TIMING_REQ  = 2'b10;
  localparam logic [1:0] LOW2_COMMAND     = 2'b01;
  localparam logic [1:0] LOW2_NEW_TIMINGS = 2'b11;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_START   = 2'd1,
    PH_COLLECT = 2'd2
  } fcd_phase_t;

  typedef enum logic [1:0] {
    KIND_TIMING_REQ  = 2'd0,
    KIND_COMMAND     = 2'd1,
    KIND_NEW_TIMINGS = 2'd2,
    KIND_MALFORMED   = 2'd3
  } fcd_kind_t;

  // Closed packet handed from the deframer to the classifier
  typedef struct packed {
    logic                             valid;
    logic                             len_one;
    logic                             len_two;
    logic                             len_nine;
    logic [TIMING_LEN-1:0][7:0]       bytes;
  } fcd_pkt_t;

  typedef struct packed {
    fcd_kind_t   packet_kind;
    logic [6:0]  command_flags;
    logic [1:0]  camera_state;
    logic [15:0] rebound_delay;
    logic [15:0] relay_delay;
    logic [15:0] front_show_delay;
    logic [15:0] rear_show_delay;
    logic [15:0] error_count;
  } fcd_result_t;

endpackage

`default_nettype wire

[hw/rtl/fcd_if.sv]
// ----------------------------------------------------------------------------
// fcd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_kind;
  logic [6:0]  command_flags;
  logic [1:0]  camera_state;
  logic [15:0] rebound_delay;
  logic [15:0] relay_delay;
  logic [15:0] front_show_delay;
  logic [15:0] rear_show_delay;
  logic [15:0] error_count;

  modport source (
    output valid, output packet_kind, output command_flags, output camera_state,
    output rebound_delay, output relay_delay, output front_show_delay,
    output rear_show_delay, output error_count, input ready
  );
  modport sink (
    input valid, input packet_kind, input command_flags, input camera_state,
    input rebound_delay, input relay_delay, input front_show_delay,
    input rear_show_delay, input error_count, output ready
  );
endinterface

`default_nettype wire

[hw/rtl/fcd_deframer.sv]
// ----------------------------------------------------------------------------
// fcd_deframer
// Frame hunter and payload gatherer. Emits a closed packet in the cycle its
// closing border byte, or its last payload byte, is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_deframer #(
  parameter int unsigned MAX_PAYLOAD = 9
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [7:0]      border_byte,
  input  wire logic [7:0]      start_byte,
  output fcd_pkg::fcd_pkt_t    pkt
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W = CNT_W + 1;

  fcd_pkg::fcd_phase_t phase, phase_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [7:0]          payload [MAX_PAYLOAD];

  logic             is_border;
  logic             is_start;
  logic [LEN_W-1:0] pkt_len;
  logic             full;
  logic             store_en;

  assign is_border = (rx_byte == border_byte);
  assign is_start  = (rx_byte == start_byte);

  // length of the packet if it closes on this byte
  assign pkt_len = is_border ? {1'b0, count} : ({1'b0, count} + LEN_W'(1));
  assign full    = !is_border && (pkt_len == LEN_W'(MAX_PAYLOAD));

  // next phase and fill count
  always_comb begin
    phase_next = phase;
    count_next = count;
    if (accept) begin
      case (phase)
        fcd_pkg::PH_HUNT: begin
          if (is_border) phase_next = fcd_pkg::PH_START;
        end
        fcd_pkg::PH_START: begin
          // start byte wins over border when both match
          if (is_start) begin
            phase_next = fcd_pkg::PH_COLLECT;
            count_next = '0;
          end else if (!is_border) begin
            phase_next = fcd_pkg::PH_HUNT;
          end
        end
        fcd_pkg::PH_COLLECT: begin
          if (is_border || full) begin
            phase_next = fcd_pkg::PH_HUNT;
            count_next = '0;
          end else begin
            count_next = pkt_len[CNT_W-1:0];
          end
        end
        default: phase_next = fcd_pkg::PH_HUNT;
      endcase
    end
  end

  // packet event and merged byte view (the incoming byte may be the last one)
  always_comb begin
    store_en     = accept && (phase == fcd_pkg::PH_COLLECT) && !is_border;
    pkt.valid    = accept && (phase == fcd_pkg::PH_COLLECT) &&
                   (is_border ? (count != '0) : full);
    pkt.len_one  = (pkt_len == LEN_W'(1));
    pkt.len_two  = (pkt_len == LEN_W'(2));
    pkt.len_nine = (pkt_len == LEN_W'(fcd_pkg::TIMING_LEN));
    for (int i = 0; i < fcd_pkg::TIMING_LEN; i++) begin
      pkt.bytes[i] = (!is_border && (LEN_W'(i) == {1'b0, count})) ? rx_byte : payload[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fcd_pkg::PH_HUNT;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // payload buffer, no reset: only gathered entries are ever used
  always_ff @(posedge clk) begin
    if (store_en) payload[count] <= rx_byte;
  end

endmodule

`default_nettype wire

[hw/rtl/fcd_classify.sv]
// ----------------------------------------------------------------------------
// fcd_classify
// Sorts a closed packet by length and signature bits, unpacks its fields and
// keeps the wrapping malformed-packet tally.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_classify (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fcd_pkg::fcd_pkt_t pkt,
  output fcd_pkg::fcd_result_t  rslt
);

  logic [15:0] tally, tally_next;
  logic [1:0]  low2;

  assign low2 = pkt.bytes[0][1:0];

  // decode; unused fields stay zero
  always_comb begin
    rslt       = '0;
    tally_next = tally;
    if (pkt.len_one && (low2 == fcd_pkg::LOW2_TIMING_REQ)) begin
      rslt.packet_kind = fcd_pkg::KIND_TIMING_REQ;
    end else if (pkt.len_two && (low2 == fcd_pkg::LOW2_COMMAND)) begin
      rslt.packet_kind   = fcd_pkg::KIND_COMMAND;
      rslt.command_flags = {pkt.bytes[1][0], pkt.bytes[0][7:2]};
      rslt.camera_state  = pkt.bytes[1][2:1];
    end else if (pkt.len_nine && (low2 == fcd_pkg::LOW2_NEW_TIMINGS)) begin
      rslt.packet_kind      = fcd_pkg::KIND_NEW_TIMINGS;
      rslt.rebound_delay    = {pkt.bytes[2], pkt.bytes[1]};
      rslt.relay_delay      = {pkt.bytes[4], pkt.bytes[3]};
      rslt.front_show_delay = {pkt.bytes[6], pkt.bytes[5]};
      rslt.rear_show_delay  = {pkt.bytes[8], pkt.bytes[7]};
    end else begin
      rslt.packet_kind = fcd_pkg::KIND_MALFORMED;
      tally_next       = tally + 16'd1;
    end
    rslt.error_count = tally_next;
  end

  // tally moves only when a packet is really classified
  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (pkt.valid) begin
      tally <= tally_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/framed_command_deframer.sv]
// Output: the result is registered from the byte that closes its packet
//   (closing border, or the last byte of a full payload) when it is accepted.
// Throughput: one received byte per cycle; a two-entry output queue (register
//   plus skid) lets bytes flow while one result waits, but not while two do.
// Reset (synchronous): hunting for a border, empty count, error tally zero,
//   output queue empty, border/start registers back to 126/85.
// ----------------------------------------------------------------------------
// framed_command_deframer
// Deframes border/start delimited command packets and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_command_deframer #(
  parameter int unsigned MAX_PAYLOAD = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  fcd_rx_if.sink                             rx,
  fcd_res_if.source                          res
);

  logic [7:0] border_byte;
  logic [7:0] start_byte;

  logic                 rx_accept;
  fcd_pkg::fcd_pkt_t    pkt;
  fcd_pkg::fcd_result_t rslt;

  logic                 out_valid;
  fcd_pkg::fcd_result_t out_pay;
  logic                 skid_valid;
  fcd_pkg::fcd_result_t skid_pay;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      border_byte <= fcd_pkg::BORDER_RESET;
      start_byte  <= fcd_pkg::START_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fcd_pkg::REG_BORDER: border_byte <= cfg_data;
        fcd_pkg::REG_START:  start_byte  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input request taken whenever the skid slot is free
  assign rx.ready  = !skid_valid;
  assign rx_accept = rx.valid && rx.ready;

  fcd_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_deframer (
    .clk         (clk),
    .rst         (rst),
    .accept      (rx_accept),
    .rx_byte     (rx.rx_byte),
    .border_byte (border_byte),
    .start_byte  (start_byte),
    .pkt         (pkt)
  );

  fcd_classify u_classify (
    .clk  (clk),
    .rst  (rst),
    .pkt  (pkt),
    .rslt (rslt)
  );

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !res.ready) begin
      if (pkt.valid) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !res.ready) begin
      if (pkt.valid) skid_pay <= rslt;
    end else if (skid_valid) begin
      out_pay <= skid_pay;
    end else if (pkt.valid) begin
      out_pay <= rslt;
    end
  end

  assign res.valid            = out_valid;
  assign res.packet_kind      = out_pay.packet_kind;
  assign res.command_flags    = out_pay.command_flags;
  assign res.camera_state     = out_pay.camera_state;
  assign res.rebound_delay    = out_pay.rebound_delay;
  assign res.relay_delay      = out_pay.relay_delay;
  assign res.front_show_delay = out_pay.front_show_delay;
  assign res.rear_show_delay  = out_pay.rear_show_delay;
  assign res.error_count      = out_pay.error_count;

  // skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  // packets only arise from an accepted byte
  a_pkt_needs_accept: assert property (@(posedge clk) disable iff (rst)
    pkt.valid |-> rx_accept)
    else $error("packet event without accepted byte");

  // delay fields are zero unless the packet carries new timings
  a_delays_zero: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && (rslt.packet_kind != fcd_pkg::KIND_NEW_TIMINGS)) |->
      (rslt.rebound_delay == 16'd0 && rslt.relay_delay == 16'd0 &&
       rslt.front_show_delay == 16'd0 && rslt.rear_show_delay == 16'd0))
    else $error("delay fields set on a non-timing packet");

endmodule

`default_nettype wire

[tb/sv/fcd_checker.sv]
// ----------------------------------------------------------------------------
// fcd_checker
// Watches the byte and result channels of the framed command deframer, keeps
// its own model of framing, classification and error tally, and compares
// every result it sees, field by field, with the oldest predicted packet.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_checker #(
  parameter int unsigned MAX_PAYLOAD = 9
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  fcd_rx_if                                  rx,
  fcd_res_if                                 res,
  output int unsigned                        fail_count,
  output int unsigned                        pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // Model state
  logic [7:0]          border_val;
  logic [7:0]          start_val;
  fcd_pkg::fcd_phase_t link_phase;
  logic [7:0]          gathered [MAX_PAYLOAD];
  int unsigned         gathered_len;
  logic [15:0]         malformed_tally;

  fcd_pkg::fcd_result_t expected_packets [$];
  int unsigned          mism;

  // Classify the gathered bytes; a malformed packet bumps the tally first
  function automatic fcd_pkg::fcd_result_t classify_packet();
    fcd_pkg::fcd_result_t r;
    logic [1:0]           sig;
    r   = '0;
    sig = gathered[0][1:0];
    if (gathered_len == 1 && sig == fcd_pkg::LOW2_TIMING_REQ) begin
      r.packet_kind = fcd_pkg::KIND_TIMING_REQ;
    end else if (gathered_len == 2 && sig == fcd_pkg::LOW2_COMMAND) begin
      r.packet_kind   = fcd_pkg::KIND_COMMAND;
      r.command_flags = {gathered[1][0], gathered[0][7:2]};
      r.camera_state  = gathered[1][2:1];
    end else if (gathered_len == fcd_pkg::TIMING_LEN &&
                 sig == fcd_pkg::LOW2_NEW_TIMINGS) begin
      r.packet_kind      = fcd_pkg::KIND_NEW_TIMINGS;
      r.rebound_delay    = {gathered[2], gathered[1]};
      r.relay_delay      = {gathered[4], gathered[3]};
      r.front_show_delay = {gathered[6], gathered[5]};
      r.rear_show_delay  = {gathered[8], gathered[7]};
    end else begin
      r.packet_kind   = fcd_pkg::KIND_MALFORMED;
      malformed_tally = malformed_tally + 16'd1;
    end
    r.error_count = malformed_tally;
    return r;
  endfunction

  // Advance the framing model by one received byte
  function automatic void absorb_byte(input logic [7:0] b);
    case (link_phase)
      fcd_pkg::PH_HUNT: begin
        if (b == border_val) link_phase = fcd_pkg::PH_START;
      end
      fcd_pkg::PH_START: begin
        // start byte wins when border and start share a value
        if (b == start_val) begin
          link_phase   = fcd_pkg::PH_COLLECT;
          gathered_len = 0;
        end else if (b != border_val) begin
          link_phase = fcd_pkg::PH_HUNT;
        end
      end
      fcd_pkg::PH_COLLECT: begin
        if (b == border_val) begin
          // closing border is consumed; an empty packet yields nothing
          link_phase = fcd_pkg::PH_HUNT;
          if (gathered_len != 0) expected_packets.push_back(classify_packet());
          gathered_len = 0;
        end else begin
          gathered[gathered_len] = b;
          gathered_len++;
          if (gathered_len == MAX_PAYLOAD) begin
            link_phase = fcd_pkg::PH_HUNT;
            expected_packets.push_back(classify_packet());
            gathered_len = 0;
          end
        end
      end
      default: link_phase = fcd_pkg::PH_HUNT;
    endcase
  endfunction

  function automatic void check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mism++;
      $display("%0t %s mismatch: expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  // Compare results, then track accepted bytes and register writes
  always @(posedge clk) begin
    fcd_pkg::fcd_result_t want;
    if (rst) begin
      border_val      = fcd_pkg::BORDER_RESET;
      start_val       = fcd_pkg::START_RESET;
      link_phase      = fcd_pkg::PH_HUNT;
      gathered_len    = 0;
      malformed_tally = '0;
      mism            = 0;
      expected_packets.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_packets.size() == 0) begin
          mism++;
          $display("%0t unexpected result: expected none, got kind %0d errors %0h",
                   $time, res.packet_kind, res.error_count);
        end else begin
          want = expected_packets.pop_front();
          check_field("packet_kind", want.packet_kind, res.packet_kind);
          check_field("command_flags", want.command_flags, res.command_flags);
          check_field("camera_state", want.camera_state, res.camera_state);
          check_field("rebound_delay", want.rebound_delay, res.rebound_delay);
          check_field("relay_delay", want.relay_delay, res.relay_delay);
          check_field("front_show_delay", want.front_show_delay, res.front_show_delay);
          check_field("rear_show_delay", want.rear_show_delay, res.rear_show_delay);
          check_field("error_count", want.error_count, res.error_count);
        end
      end
      // a write lands after any byte taken on the same edge
      if (rx.valid && rx.ready) absorb_byte(rx.rx_byte);
      if (cfg_we) begin
        if (cfg_index == fcd_pkg::REG_BORDER) border_val = cfg_data;
        else if (cfg_index == fcd_pkg::REG_START) start_val = cfg_data;
      end
    end
    fail_count <= mism;
    pending    <= expected_packets.size();
  end

endmodule

`default_nettype wire

[tb/sv/tb_framed_command_deframer.sv]
// ----------------------------------------------------------------------------
// tb_framed_command_deframer
// Drives framed byte streams into the deframer under several border/start
// settings and idle patterns. Checking is done by fcd_checker beside the
// block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_framed_command_deframer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAYLOAD     = 9;
  localparam int unsigned ITEMS_PER_PHASE = 450;
  localparam int unsigned SETTLE_CYCLES   = 8;

  // Opening frames at reset values: timing request, command with every flag,
  // full timings payload (no closer), empty packet, repeated border
  localparam logic [7:0] DIRECTED [28] = '{
    fcd_pkg::BORDER_RESET, fcd_pkg::START_RESET, 8'hFE, fcd_pkg::BORDER_RESET,
    fcd_pkg::BORDER_RESET, fcd_pkg::START_RESET, 8'hFD, 8'hFF,
    fcd_pkg::BORDER_RESET,
    fcd_pkg::BORDER_RESET, fcd_pkg::START_RESET, 8'h03, 8'hFF, 8'hFF, 8'h00,
    8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
    fcd_pkg::BORDER_RESET, fcd_pkg::START_RESET, fcd_pkg::BORDER_RESET,
    fcd_pkg::BORDER_RESET, fcd_pkg::BORDER_RESET, fcd_pkg::START_RESET, 8'h00,
    fcd_pkg::BORDER_RESET
  };

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [fcd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;

  fcd_rx_if  rx_ch ();
  fcd_res_if res_ch ();

  int unsigned fail_count;
  int unsigned pending;

  int unsigned src_idle;
  int unsigned sink_stall;
  int unsigned sent_items;
  logic [7:0]  cur_border;
  logic [7:0]  cur_start;

  framed_command_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  fcd_checker #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx         (rx_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  initial begin
    #1_000_000;
    $display("[framed_command_deframer] ERROR");
    $finish;
  end

  // One byte request; valid stays high into the next call unless it idles
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sent_items++;
  endtask

  // Payload byte that does not close the frame early
  function automatic logic [7:0] body_byte();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    if (v == cur_border) v ^= 8'h01;
    return v;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [1:0] sig);
    logic [7:0] v;
    v      = 8'($urandom_range(255));
    v[1:0] = sig;
    if (v == cur_border) v[7] = ~v[7];
    return v;
  endfunction

  task automatic send_preamble();
    send_byte(cur_border);
    if ($urandom_range(7) == 0) repeat ($urandom_range(2, 1)) send_byte(cur_border);
    send_byte(cur_start);
  endtask

  // One random frame, mostly well formed
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_preamble();
      send_byte(sig_byte(fcd_pkg::LOW2_TIMING_REQ));
      send_byte(cur_border);
    end else if (pick < 40) begin
      send_preamble();
      send_byte(sig_byte(fcd_pkg::LOW2_COMMAND));
      send_byte(body_byte());
      send_byte(cur_border);
    end else if (pick < 60) begin
      send_preamble();
      send_byte(sig_byte(fcd_pkg::LOW2_NEW_TIMINGS));
      repeat (fcd_pkg::TIMING_LEN - 1) send_byte(body_byte());
      if ($urandom_range(3) == 0) send_byte(cur_border);
    end else if (pick < 75) begin
      // arbitrary length and content, sometimes with a stray border inside
      send_preamble();
      len = $urandom_range(MAX_PAYLOAD, 1);
      repeat (len) begin
        if ($urandom_range(1) == 0) send_byte(body_byte());
        else send_byte(8'($urandom_range(255)));
      end
      if (len < MAX_PAYLOAD) send_byte(cur_border);
    end else if (pick < 83) begin
      // broken opening: border then a byte that is not a border
      send_byte(cur_border);
      send_byte(body_byte());
    end else if (pick < 90) begin
      send_preamble();
      send_byte(cur_border);
    end else begin
      // line noise does not count towards the item budget
      len = $urandom_range(6, 1);
      repeat (len) send_byte(8'($urandom_range(255)));
      sent_items -= len;
    end
  endtask

  // Wait for every predicted packet, then for the pipeline to settle
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] border_v, input logic [7:0] start_v);
    cfg_we    <= 1'b1;
    cfg_index <= fcd_pkg::REG_BORDER;
    cfg_data  <= border_v;
    @(posedge clk);
    cfg_index <= fcd_pkg::REG_START;
    cfg_data  <= start_v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_border  = border_v;
    cur_start   = start_v;
  endtask

  initial begin
    int unsigned ph;
    logic [7:0]  nb;
    logic [7:0]  ns;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= fcd_pkg::REG_BORDER;
    cfg_data      <= 8'h00;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    src_idle   = 0;
    sink_stall = 0;
    sent_items = 0;
    cur_border = fcd_pkg::BORDER_RESET;
    cur_start  = fcd_pkg::START_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at reset register values
    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    wait_drained();

    // Random phases: register extremes, equal values, then random values
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          nb = 8'h00; ns = 8'hFF; src_idle = 0;  sink_stall = 0;
        end
        1: begin
          nb = 8'hFF; ns = 8'h00; src_idle = 81; sink_stall = 0;
        end
        2: begin
          nb = 8'hA5; ns = 8'hA5; src_idle = 0;  sink_stall = 81;
        end
        default: begin
          nb = 8'($urandom_range(255)); ns = 8'($urandom_range(255));
          src_idle = 22; sink_stall = 22;
        end
      endcase
      write_regs(nb, ns);
      sent_items = 0;
      while (sent_items < ITEMS_PER_PHASE) send_random_frame();
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("[framed_command_deframer] OK");
    end else begin
      $display("[framed_command_deframer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/fcd_pkg.sv
hw/rtl/fcd_if.sv
hw/rtl/fcd_deframer.sv
hw/rtl/fcd_classify.sv
hw/rtl/framed_command_deframer.sv
tb/sv/fcd_checker.sv
tb/sv/tb_framed_command_deframer.sv
